// ===== src/aspm_pkg.sv =====
// ----------------------------------------------------------------------------
// aspm_pkg
// Shared types and constants for the anemometer pulse speed meter: item
// layouts, command and register codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package aspm_pkg;

	// field widths
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 32;
	localparam int SPEED_W  = 32;
	localparam int LOCK_W   = 16;
	localparam int CPP_W    = 8;
	localparam int SCALE_W  = 24;
	localparam int PROD_W   = COUNT_W + SCALE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// divider sizing: one quotient bit per step
	localparam int DIV_STEPS = SPEED_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

	// reset values of the configuration registers
	localparam logic [LOCK_W-1:0]  LOCKOUT_RST = LOCK_W'(50);
	localparam logic [CPP_W-1:0]   CPP_RST     = CPP_W'(3);
	localparam logic [SCALE_W-1:0] SCALE_RST   = SCALE_W'(20000);

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_PULSE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] avg_speed;
		logic [SPEED_W-1:0] peak_speed;
		logic [COUNT_W-1:0] total_clicks;
		logic               click_accepted;
		logic               zero_interval;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic eval;
		logic mul;
		logic div_init;
		logic div_step;
		logic apply;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_speed;
		logic saturate;
	} dp_status_t;

endpackage

// ===== src/aspm_ctrl.sv =====
// ----------------------------------------------------------------------------
// aspm_ctrl
// Speed meter sequencer: takes one item at a time, steps the datapath through
// evaluate, multiply, divide and apply (when a speed is needed), result load.
// ----------------------------------------------------------------------------
module aspm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  aspm_pkg::dp_status_t status,
	output aspm_pkg::dp_cmd_t    cmd
);
	import aspm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_APPLY,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   div_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign div_last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// datapath commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:     cmd.load_item = in_valid;
			S_EVAL:     cmd.eval      = 1'b1;
			S_MUL:      cmd.mul       = 1'b1;
			S_DIV_INIT: cmd.div_init  = 1'b1;
			S_DIV:      cmd.div_step  = 1'b1;
			S_APPLY:    cmd.apply     = 1'b1;
			S_DONE:     cmd.load_out  = out_free;
			default:    cmd = '0;
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on load, cleared when taken
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= status.need_speed ? S_MUL : S_DONE;
				end
				S_MUL: begin
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= status.saturate ? S_APPLY : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last)
						state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/aspm_dp.sv =====
// ----------------------------------------------------------------------------
// aspm_dp
// Datapath of the speed meter: configuration and click state, the 32x24
// multiplier, a radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
module aspm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  aspm_pkg::in_item_t                   in_data,
	output aspm_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [aspm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [aspm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  aspm_pkg::dp_cmd_t                    cmd,
	output aspm_pkg::dp_status_t                 status
);
	import aspm_pkg::*;

	// configuration
	logic [LOCK_W-1:0]  lockout_q;
	logic [CPP_W-1:0]   cpp_q;
	logic [SCALE_W-1:0] scale_q;

	// meter state
	logic [COUNT_W-1:0] click_count_q;
	logic [TIME_W-1:0]  last_click_time_q;
	logic [TIME_W-1:0]  read_ref_time_q;
	logic [COUNT_W-1:0] read_ref_count_q;
	logic [TIME_W-1:0]  peak_ref_time_q;
	logic [COUNT_W-1:0] peak_ref_count_q;
	logic [SPEED_W-1:0] peak_value_q;
	logic [CPP_W-1:0]   csp_q;

	// per-item working registers
	in_item_t           item_q;
	logic [COUNT_W-1:0] clicks_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [PROD_W-1:0]  prod_q;
	logic [TIME_W-1:0]  rem_q;
	logic [SPEED_W-1:0] quot_q;
	logic               sat_q;
	logic               zero_q;
	logic               accepted_q;
	logic               is_read_q;
	logic               is_ckpt_q;
	logic [SPEED_W-1:0] peak_hold_q;
	out_item_t          out_q;

	// decode of the held item
	logic [TIME_W-1:0]  since_click;
	logic               click_ok;
	logic [COUNT_W-1:0] count_inc;
	logic [CPP_W:0]     csp_inc;
	logic               ckpt;
	logic               is_pulse;
	logic               is_read;
	logic [PROD_W-1:0]  prod_w;
	logic               sat_w;
	logic [TIME_W:0]    trial;
	logic [TIME_W:0]    trial_diff;
	logic               trial_ge;
	logic [SPEED_W-1:0] speed_w;

	assign is_pulse    = (item_q.command == CMD_PULSE);
	assign is_read     = (item_q.command == CMD_READ);
	assign since_click = item_q.time_ms - last_click_time_q;
	assign click_ok    = is_pulse && (since_click >= TIME_W'(lockout_q));
	assign count_inc   = click_count_q + 1'b1;
	assign csp_inc     = {1'b0, csp_q} + 1'b1;
	assign ckpt        = (csp_inc >= {1'b0, cpp_q});

	assign status.need_speed = (click_ok && ckpt) || is_read;

	// quotient overflows 32 bits when the upper product bits reach the divisor;
	// a zero divisor lands here too
	assign prod_w  = PROD_W'(clicks_q) * PROD_W'(scale_q);
	assign sat_w   = (TIME_W'(prod_q[PROD_W-1:SPEED_W]) >= elapsed_q);
	assign status.saturate = sat_w;

	// one restoring division step
	assign trial      = {rem_q, quot_q[SPEED_W-1]};
	assign trial_diff = trial - {1'b0, elapsed_q};
	assign trial_ge   = (trial >= {1'b0, elapsed_q});

	assign speed_w  = sat_q ? SPEED_SAT : quot_q;
	assign out_data = out_q;

	// configuration and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q         <= LOCKOUT_RST;
			cpp_q             <= CPP_RST;
			scale_q           <= SCALE_RST;
			click_count_q     <= '0;
			last_click_time_q <= '0;
			read_ref_time_q   <= '0;
			read_ref_count_q  <= '0;
			peak_ref_time_q   <= '0;
			peak_ref_count_q  <= '0;
			peak_value_q      <= '0;
			csp_q             <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LOCKOUT: lockout_q <= cfg_data[LOCK_W-1:0];
					REG_CPP:     cpp_q     <= cfg_data[CPP_W-1:0];
					REG_SCALE:   scale_q   <= cfg_data[SCALE_W-1:0];
					default:     ;
				endcase
			end
			if (cmd.eval) begin
				case (item_q.command)
					CMD_START: begin
						peak_ref_time_q <= item_q.time_ms;
						read_ref_time_q <= item_q.time_ms;
					end
					CMD_PULSE: begin
						if (click_ok) begin
							last_click_time_q <= item_q.time_ms;
							click_count_q     <= count_inc;
							if (ckpt) begin
								peak_ref_count_q <= count_inc;
								peak_ref_time_q  <= item_q.time_ms;
								csp_q            <= '0;
							end else begin
								csp_q <= csp_inc[CPP_W-1:0];
							end
						end
					end
					CMD_READ: begin
						read_ref_count_q <= click_count_q;
						read_ref_time_q  <= item_q.time_ms;
						peak_value_q     <= '0;
					end
					default: ;
				endcase
			end
			// running peak at a checkpoint
			if (cmd.apply && is_ckpt_q && (speed_w > peak_value_q))
				peak_value_q <= speed_w;
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= in_data;
		if (cmd.eval) begin
			accepted_q  <= click_ok;
			is_read_q   <= is_read;
			is_ckpt_q   <= click_ok && ckpt;
			zero_q      <= 1'b0;
			peak_hold_q <= peak_value_q;
			if (is_read) begin
				clicks_q  <= click_count_q - read_ref_count_q;
				elapsed_q <= item_q.time_ms - read_ref_time_q;
			end else begin
				clicks_q  <= count_inc - peak_ref_count_q;
				elapsed_q <= item_q.time_ms - peak_ref_time_q;
			end
		end
		if (cmd.mul)
			prod_q <= prod_w;
		if (cmd.div_init) begin
			sat_q  <= sat_w;
			zero_q <= (elapsed_q == '0);
			rem_q  <= TIME_W'(prod_q[PROD_W-1:SPEED_W]);
			quot_q <= prod_q[SPEED_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q  <= trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
			quot_q <= {quot_q[SPEED_W-2:0], trial_ge};
		end
		if (cmd.load_out) begin
			out_q.avg_speed      <= is_read_q ? speed_w : '0;
			out_q.peak_speed     <= is_read_q ? peak_hold_q : peak_value_q;
			out_q.total_clicks   <= click_count_q;
			out_q.click_accepted <= accepted_q;
			out_q.zero_interval  <= zero_q;
		end
	end

endmodule

// ===== src/anemometer_pulse_speed_meter.sv =====
// ----------------------------------------------------------------------------
// anemometer_pulse_speed_meter
// Counts debounced anemometer clicks and reports average and peak speed.
// ----------------------------------------------------------------------------
// Flow: start, ignored or plain pulse items go from accept through evaluate to
// result load; a speed adds multiply, divider init, the 32-step radix-2 divide
// and apply, with the divide skipped when it saturates. One item at a time: the
// next is accepted once the result loads, which waits while the output stalls.
// Reset: asynchronous, clears all counts, references and peak, loads the
// default lockout, checkpoint spacing and scale; no clearing pass.
module anemometer_pulse_speed_meter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  aspm_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output aspm_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aspm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aspm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import aspm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	aspm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	aspm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

	// a zero interval always shows up as a saturated speed
	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_interval |->
			(out_data.avg_speed == SPEED_SAT) || (out_data.peak_speed == SPEED_SAT))
		else $error("zero interval without saturated speed");

	// a counted click never carries an average
	a_click_no_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.click_accepted |-> (out_data.avg_speed == '0))
		else $error("average reported on a click item");

	// an accepted item keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// result load only happens when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result register overwritten while held");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the anemometer pulse speed meter. An in-bench
// predictor tracks clicks, lockout, checkpoints and peak, and expects one
// reading per item. Directed items cover lockout, wrap and saturation. Random
// click streams then run under several idle/stall mixes and register settings,
// plus a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
	import aspm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int STREAM_LEN    = 220;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	anemometer_pulse_speed_meter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies
	logic [LOCK_W-1:0]  lockout_set;
	logic [CPP_W-1:0]   checkpoint_every;
	logic [SCALE_W-1:0] scale_set;

	// meter state copies
	logic [COUNT_W-1:0] clicks_total;
	logic [COUNT_W-1:0] read_base_clicks;
	logic [COUNT_W-1:0] peak_base_clicks;
	logic [TIME_W-1:0]  last_click_ms;
	logic [TIME_W-1:0]  read_base_ms;
	logic [TIME_W-1:0]  peak_base_ms;
	logic [SPEED_W-1:0] peak_hold;
	logic [CPP_W-1:0]   clicks_since_checkpoint;

	out_item_t pending_readings[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int hold_seq = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_clicks = 0;
	int n_saturated = 0;
	int n_input_stalls = 0;
	logic [TIME_W-1:0] now_ms;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

	// speed over an interval, saturating
	function automatic logic [SPEED_W-1:0] speed_over(input logic [COUNT_W-1:0] clicks,
			input logic [TIME_W-1:0] elapsed, output logic sat);
		logic [63:0] quo;
		sat = 1'b0;
		if (elapsed == '0) begin
			sat = 1'b1;
			return SPEED_SAT;
		end
		quo = (64'(clicks) * 64'(scale_set)) / 64'(elapsed);
		return (quo > 64'(SPEED_SAT)) ? SPEED_SAT : quo[SPEED_W-1:0];
	endfunction

	function automatic void clear_meter();
		lockout_set = LOCKOUT_RST;
		checkpoint_every = CPP_RST;
		scale_set = SCALE_RST;
		clicks_total = '0;
		read_base_clicks = '0;
		peak_base_clicks = '0;
		last_click_ms = '0;
		read_base_ms = '0;
		peak_base_ms = '0;
		peak_hold = '0;
		clicks_since_checkpoint = '0;
	endfunction

	// advance the meter copy by one item and queue the reading it gives
	function automatic void predict_reading(input in_item_t it);
		out_item_t r;
		logic sat;
		logic [SPEED_W-1:0] spd;
		r = '0;
		sat = 1'b0;
		case (it.command)
			CMD_START: begin
				peak_base_ms = it.time_ms;
				read_base_ms = it.time_ms;
			end
			CMD_PULSE: begin
				if (TIME_W'(it.time_ms - last_click_ms) >= TIME_W'(lockout_set)) begin
					r.click_accepted = 1'b1;
					last_click_ms = it.time_ms;
					clicks_total = clicks_total + 1'b1;
					// checkpoint; a spacing of zero behaves as one
					if (32'(clicks_since_checkpoint) + 32'd1 >= 32'(checkpoint_every)) begin
						spd = speed_over(clicks_total - peak_base_clicks,
							it.time_ms - peak_base_ms, sat);
						if (spd > peak_hold)
							peak_hold = spd;
						peak_base_clicks = clicks_total;
						peak_base_ms = it.time_ms;
						clicks_since_checkpoint = '0;
					end else begin
						clicks_since_checkpoint = clicks_since_checkpoint + 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.peak_speed = peak_hold;
		if (it.command == CMD_READ) begin
			r.avg_speed = speed_over(clicks_total - read_base_clicks,
				it.time_ms - read_base_ms, sat);
			read_base_clicks = clicks_total;
			read_base_ms = it.time_ms;
			peak_hold = '0;
		end
		r.total_clicks = clicks_total;
		r.zero_interval = sat;
		if (r.click_accepted)
			n_clicks++;
		if (sat)
			n_saturated++;
		pending_readings.push_back(r);
	endfunction

	function automatic void note_mismatch(input string what, input out_item_t want,
			input out_item_t got);
		n_mismatch++;
		if (n_mismatch <= 10) begin
			$display("%s: expected avg=%0d peak=%0d clicks=%0d acc=%0b zero=%0b", what,
				want.avg_speed, want.peak_speed, want.total_clicks, want.click_accepted,
				want.zero_interval);
			$display("%s: actual   avg=%0d peak=%0d clicks=%0d acc=%0b zero=%0b", what,
				got.avg_speed, got.peak_speed, got.total_clicks, got.click_accepted,
				got.zero_interval);
		end
	endfunction

	// reading checker and output stall driver
	initial begin
		int hold_left;
		int seen_seq;
		out_item_t want;
		hold_left = 0;
		seen_seq = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_readings.size() == 0) begin
					note_mismatch("unexpected reading", '0, out_data);
				end else begin
					want = pending_readings.pop_front();
					n_checked++;
					if (out_data.avg_speed !== want.avg_speed ||
							out_data.peak_speed !== want.peak_speed ||
							out_data.total_clicks !== want.total_clicks ||
							out_data.click_accepted !== want.click_accepted ||
							out_data.zero_interval !== want.zero_interval)
						note_mismatch("reading mismatch", want, out_data);
				end
			end
			// long hold-off on request, else random stalls
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// offer one item, with a random idle gap first, and wait for accept
	task automatic send_item(input logic [1:0] cmd, input logic [TIME_W-1:0] t);
		in_item_t it;
		int gap;
		it.command = cmd;
		it.time_ms = t;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) begin
			n_input_stalls++;
			@(posedge clk);
		end
		predict_reading(it);
		n_sent++;
	endtask

	// stop offering and let every expected reading arrive
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers; block must be idle
	task automatic configure(input logic [LOCK_W-1:0] lock, input logic [CPP_W-1:0] cpp,
			input logic [SCALE_W-1:0] scale);
		logic [CFG_IDX_W-1:0] regs[3];
		logic [CFG_DATA_W-1:0] vals[3];
		regs[0] = REG_LOCKOUT;
		regs[1] = REG_CPP;
		regs[2] = REG_SCALE;
		vals[0] = CFG_DATA_W'(lock);
		vals[1] = CFG_DATA_W'(cpp);
		vals[2] = CFG_DATA_W'(scale);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		lockout_set = lock;
		checkpoint_every = cpp;
		scale_set = scale;
	endtask

	// defaults after reset: lockout, checkpoint, zero interval, time wrap
	task automatic test_directed_defaults();
		send_item(CMD_PULSE, 32'd10);
		send_item(CMD_PULSE, 32'd50);
		send_item(CMD_PULSE, 32'd60);
		send_item(CMD_PULSE, 32'd100);
		send_item(CMD_PULSE, 32'd150);
		send_item(CMD_READ, 32'd150);
		send_item(CMD_READ, 32'd150);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF);
		send_item(CMD_START, 32'hFFFF_FFF0);
		send_item(CMD_PULSE, 32'hFFFF_FFFF);
		send_item(CMD_PULSE, 32'h0000_002F);
		send_item(CMD_PULSE, 32'h0000_0031);
		send_item(CMD_PULSE, 32'h0000_0063);
		send_item(CMD_READ, 32'h0000_0063);
		send_item(CMD_START, 32'd0);
		send_item(CMD_READ, 32'd0);
	endtask

	// register extremes: no lockout, max scale, max spacing, zero spacing and scale
	task automatic test_register_extremes();
		logic [TIME_W-1:0] base;
		settle();
		configure('0, 8'd1, '1);
		base = $urandom;
		send_item(CMD_START, base);
		send_item(CMD_PULSE, base);
		// enough clicks in one ms to overflow the quotient
		repeat (300) send_item(CMD_PULSE, base + 1);
		send_item(CMD_READ, base + 1);

		settle();
		configure('1, '1, 24'd1);
		base = last_click_ms;
		send_item(CMD_START, base);
		send_item(CMD_PULSE, base + 32'd65534);
		send_item(CMD_PULSE, base + 32'd65535);
		send_item(CMD_READ, base + 32'd66535);

		settle();
		configure(16'd7, '0, '0);
		base = $urandom;
		send_item(CMD_START, base);
		send_item(CMD_PULSE, base + 7);
		send_item(CMD_PULSE, base + 14);
		send_item(CMD_PULSE, base + 20);
		send_item(CMD_READ, base + 20);
		send_item(CMD_READ, base + 20);
		send_item(CMD_PULSE, base + 40);
		send_item(CMD_READ, base + 90);
		now_ms = base + 90;
	endtask

	// well-formed click stream with random content and some noise
	task automatic run_stream(input int n);
		int r;
		send_item(CMD_START, now_ms);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 5) begin
				now_ms = now_ms + $urandom_range(0, 10);
				send_item(CMD_START, now_ms);
			end else if (r < 15) begin
				now_ms = now_ms + $urandom_range(0, 32'(lockout_set) + 1);
				send_item(CMD_READ, now_ms);
			end else if (r < 17) begin
				send_item(CMD_UNUSED, $urandom);
			end else if (r < 20) begin
				send_item(CMD_PULSE, $urandom);
			end else begin
				if ($urandom_range(4) != 0)
					now_ms = now_ms + 32'(lockout_set) +
						$urandom_range(0, 32'(lockout_set) / 2 + 3);
				else
					now_ms = now_ms + $urandom_range(0, 32'(lockout_set));
				send_item(CMD_PULSE, now_ms);
			end
		end
	endtask

	// random streams under each idle/stall mix
	task automatic test_random_phases();
		int idle_mix[4];
		int stall_mix[4];
		logic [LOCK_W-1:0] lock;
		logic [CPP_W-1:0] cpp;
		logic [SCALE_W-1:0] scale;
		int r;
		idle_mix = '{0, 62, 0, 15};
		stall_mix = '{0, 0, 62, 15};
		for (int p = 0; p < 4; p++) begin
			settle();
			idle_pct = idle_mix[p];
			stall_pct = stall_mix[p];
			case ($urandom_range(3))
				0: lock = LOCK_W'($urandom_range(0, 20));
				1: lock = LOCK_W'($urandom_range(20, 300));
				2: lock = LOCK_W'($urandom);
				default: lock = LOCKOUT_RST;
			endcase
			r = $urandom_range(9);
			if (r < 7)
				cpp = CPP_W'($urandom_range(1, 8));
			else if (r == 7)
				cpp = '1;
			else if (r == 8)
				cpp = '0;
			else
				cpp = CPP_W'($urandom);
			if ($urandom_range(2) == 0)
				scale = SCALE_W'($urandom);
			else
				scale = SCALE_W'($urandom_range(1, 100000));
			configure(lock, cpp, scale);
			now_ms = $urandom;
			run_stream(STREAM_LEN);
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	// long output hold-off while items keep coming
	task automatic test_input_backpressure();
		settle();
		configure(16'd10, 8'd2, 24'd1000);
		hold_len = 300;
		hold_seq++;
		send_item(CMD_START, now_ms);
		for (int i = 0; i < 40; i++) begin
			now_ms = now_ms + $urandom_range(8, 20);
			send_item((i % 8 == 7) ? CMD_READ : CMD_PULSE, now_ms);
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		now_ms = '0;
		clear_meter();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_random_phases();
		test_input_backpressure();
		settle();

		$display("covered %0d items, %0d readings checked, %0d clicks counted, %0d saturated",
			n_sent, n_checked, n_clicks, n_saturated);
		$display("register extremes, four idle/stall mixes, %0d input stall cycles, %0d bad",
			n_input_stalls, n_mismatch);
		if (n_mismatch == 0 && pending_readings.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
